// File: hdl/nfa_active_set_simulator_defines.svh
// Assertion macros shared by the RTL files of the active-set simulator.
`ifndef NFA_ACTIVE_SET_SIMULATOR_DEFINES_SVH
`define NFA_ACTIVE_SET_SIMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset only.
`define NFAS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define NFAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NFAS_ASSERT(lbl, clk, rst_n, prop, msg)
`define NFAS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/nfas_pkg.sv
package nfas_pkg;

  // Default sizes.
  localparam int unsigned NUM_STATES_DEF = 16;
  localparam int unsigned MAX_TRANS_DEF  = 64;

  // Fixed field widths.
  localparam int unsigned STATE_W = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned REG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_START_STATE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FINAL_MASK  = 1'd1;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_BEGIN  = 2'd2,
    ACT_FEED   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } eng_state_t;

  typedef struct packed {
    action_t            action;
    logic [IDX_W-1:0]   src_state;
    logic [SYM_W-1:0]   symbol;
    logic [IDX_W-1:0]   dst_state;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] src_state;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] dst_state;
  } tt_entry_t;

  typedef struct packed {
    logic               table_full;
    logic [STATE_W-1:0] active_set;
    logic               dead;
    logic               accepted;
  } result_t;

  // One-hot bit of a state; indexes at or above the state count give no bit.
  function automatic logic [STATE_W-1:0] state_bit(input logic [IDX_W-1:0] idx,
                                                   input int unsigned n);
    logic [STATE_W-1:0] b;
    b = '0;
    if (32'(idx) < n) begin
      b = STATE_W'(1) << idx;
    end
    return b;
  endfunction

endpackage

// File: hdl/nfas_engine.sv
`include "nfa_active_set_simulator_defines.svh"

module nfas_engine #(
  parameter int unsigned NUM_STATES      = nfas_pkg::NUM_STATES_DEF,
  parameter int unsigned MAX_TRANSITIONS = nfas_pkg::MAX_TRANS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_vld,
  input  nfas_pkg::item_t               item,
  output logic                          item_rdy,
  input  logic [nfas_pkg::IDX_W-1:0]    start_state,
  input  logic [nfas_pkg::STATE_W-1:0]  final_mask,
  output logic                          res_vld,
  input  logic                          res_ack,
  output nfas_pkg::result_t             res
);

  localparam int unsigned AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_TRANSITIONS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TRANSITIONS);

  nfas_pkg::eng_state_t            state_r, state_nxt;
  nfas_pkg::item_t                 item_r, item_nxt;
  nfas_pkg::result_t               res_r, res_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic [nfas_pkg::STATE_W-1:0]    acc_r, acc_nxt;
  logic [nfas_pkg::STATE_W-1:0]    active_r, active_nxt;

  // Transition table: single port, registered read.
  nfas_pkg::tt_entry_t             mem [MAX_TRANSITIONS];
  nfas_pkg::tt_entry_t             mem_q_r;
  logic                            mem_we;
  logic [AW-1:0]                   mem_addr;
  nfas_pkg::tt_entry_t             mem_wd;

  logic                            fin;
  logic                            full_flag;
  logic [nfas_pkg::STATE_W-1:0]    new_act;
  logic                            hit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q_r <= mem[mem_addr];
  end

  // A transition fires when its label matches and its source is active.
  assign hit = (mem_q_r.symbol == item_r.symbol) &&
               (|(active_r & nfas_pkg::state_bit(mem_q_r.src_state, NUM_STATES)));

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    active_nxt  = active_r;
    rd_pend_nxt = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = idx_r[AW-1:0];
    mem_wd      = '{src_state: item_r.src_state, symbol: item_r.symbol,
                    dst_state: item_r.dst_state};
    fin         = 1'b0;
    full_flag   = 1'b0;
    new_act     = active_r;

    unique case (state_r)
      nfas_pkg::ST_IDLE: begin
        if (item_vld) begin
          item_nxt  = item;
          state_nxt = nfas_pkg::ST_EXEC;
        end
      end
      nfas_pkg::ST_EXEC: begin
        unique case (item_r.action)
          nfas_pkg::ACT_CLEAR: begin
            cnt_nxt = '0;
            fin     = 1'b1;
          end
          nfas_pkg::ACT_APPEND: begin
            if (cnt_r >= MAX_CNT) begin
              full_flag = 1'b1;
            end else begin
              mem_we   = 1'b1;
              mem_addr = cnt_r[AW-1:0];
              cnt_nxt  = cnt_r + CW'(1);
            end
            fin = 1'b1;
          end
          nfas_pkg::ACT_BEGIN: begin
            new_act    = nfas_pkg::state_bit(start_state, NUM_STATES);
            active_nxt = new_act;
            fin        = 1'b1;
          end
          nfas_pkg::ACT_FEED: begin
            idx_nxt   = '0;
            acc_nxt   = '0;
            state_nxt = nfas_pkg::ST_SCAN;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      nfas_pkg::ST_SCAN: begin
        if (rd_pend_r && hit) begin
          acc_nxt = acc_r | nfas_pkg::state_bit(mem_q_r.dst_state, NUM_STATES);
        end
        if (idx_r < cnt_r) begin
          mem_addr    = idx_r[AW-1:0];
          idx_nxt     = idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          // Every entry has been read and folded in.
          new_act    = acc_r;
          active_nxt = acc_r;
          fin        = 1'b1;
        end
      end
      nfas_pkg::ST_DONE: begin
        if (res_ack) begin
          state_nxt = nfas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nfas_pkg::ST_IDLE;
      end
    endcase

    res_nxt = res_r;
    if (fin) begin
      res_nxt.table_full = full_flag;
      res_nxt.active_set = new_act;
      res_nxt.dead       = ~|new_act;
      res_nxt.accepted   = |(new_act & final_mask);
      state_nxt          = nfas_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= nfas_pkg::ST_IDLE;
      cnt_r     <= '0;
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      active_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      rd_pend_r <= rd_pend_nxt;
      active_r  <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  assign item_rdy = (state_r == nfas_pkg::ST_IDLE);
  assign res_vld  = (state_r == nfas_pkg::ST_DONE);
  assign res      = res_r;

  `NFAS_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= MAX_CNT, "transition count above table size")
  `NFAS_ASSERT(a_idx_bound, clk, rst_n, (state_r == nfas_pkg::ST_SCAN) |-> (idx_r <= cnt_r), "scan index ran past the stored transitions")
  `NFAS_ASSERT(a_full_append, clk, rst_n, (res_vld && res_r.table_full) |-> (item_r.action == nfas_pkg::ACT_APPEND), "table_full reported for an action other than append")
  `NFAS_ASSERT(a_pend_scan, clk, rst_n, rd_pend_r |-> (state_r == nfas_pkg::ST_SCAN), "table read outstanding outside a scan")

endmodule

// File: hdl/nfa_active_set_simulator.sv
// Runs a nondeterministic finite automaton over up to 16 states, holding the set
// of active states as a 16-bit mask. Each request on the input stream names an
// action in in_tuser: clear the transition table, append one transition
// (source, symbol, destination), begin a word at the configured start state, or
// feed one symbol. Every request yields exactly one result carrying the active
// set after the action, whether it meets the final mask, whether it is empty,
// and a flag for an append that was dropped because the table was full.
// Clear, append and begin each finish in the execute state. A fed symbol
// reads every stored transition once from the single-port transition memory,
// one entry per cycle, and folds the matches into the next active set. One
// request is worked on at a time, and a finished result waits in the output
// register while the next request is taken in. The user must write
// start_state and final_mask through the cfg port only while no request is in
// flight; the block itself does not enforce this.

`include "nfa_active_set_simulator_defines.svh"

module nfa_active_set_simulator #(
  parameter int unsigned NUM_STATES      = nfas_pkg::NUM_STATES_DEF,
  parameter int unsigned MAX_TRANSITIONS = nfas_pkg::MAX_TRANS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [nfas_pkg::REG_IDX_W-1:0]  cfg_addr,
  input  logic [nfas_pkg::REG_W-1:0]      cfg_wdata,
  // Request stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // src_state[3:0], symbol[11:4],
                                                      // dst_state[15:12]
  input  logic [1:0]                      in_tuser,   // action[1:0]
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // active_set[15:0]
  output logic [2:0]                      out_tuser   // accepted[0], dead[1],
                                                      // table_full[2]
);

  logic [nfas_pkg::IDX_W-1:0]    start_r;
  logic [nfas_pkg::STATE_W-1:0]  fmask_r;

  nfas_pkg::item_t               item;
  logic                          eng_rdy;
  logic                          eng_res_vld;
  nfas_pkg::result_t             eng_res;
  logic                          load;

  logic                          out_vld_r, out_vld_nxt;
  nfas_pkg::result_t             out_res_r;

  // Configuration registers. The index is one bit wide, so every write lands
  // in one of the two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      fmask_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        nfas_pkg::REG_START_STATE: start_r <= cfg_wdata[nfas_pkg::IDX_W-1:0];
        nfas_pkg::REG_FINAL_MASK:  fmask_r <= cfg_wdata[nfas_pkg::STATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the request fields.
  always_comb begin
    item.action    = nfas_pkg::action_t'(in_tuser);
    item.src_state = in_tdata[3:0];
    item.symbol    = in_tdata[11:4];
    item.dst_state = in_tdata[15:12];
  end

  assign in_tready = eng_rdy;

  nfas_engine #(
    .NUM_STATES      (NUM_STATES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_vld    (in_tvalid),
    .item        (item),
    .item_rdy    (eng_rdy),
    .start_state (start_r),
    .final_mask  (fmask_r),
    .res_vld     (eng_res_vld),
    .res_ack     (load),
    .res         (eng_res)
  );

  // The output register takes a finished result whenever it is empty or being
  // drained in the same cycle; otherwise the engine holds the result.
  assign load = eng_res_vld && (!out_vld_r || out_tready);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= eng_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r.active_set;
  assign out_tuser  = {out_res_r.table_full, out_res_r.dead, out_res_r.accepted};

  `NFAS_ASSERT(a_cfg_start, clk, rst_n, (cfg_wr_en && cfg_addr == nfas_pkg::REG_START_STATE) |=> (start_r == $past(cfg_wdata[nfas_pkg::IDX_W-1:0])), "start state register missed a write")
  `NFAS_ASSERT(a_dead_flag, clk, rst_n, out_vld_r |-> (out_res_r.dead == (out_res_r.active_set == '0)), "dead flag disagrees with the active set")
  `NFAS_ASSERT(a_accept_flag, clk, rst_n, (out_vld_r && out_res_r.accepted) |-> (out_res_r.active_set != '0), "accepted reported with an empty active set")
  `NFAS_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_vld_r, "result valid right after reset")

endmodule

// File: test/testbench.sv
module testbench;

  // Clock, reset, hold and settle lengths, and the directed row count.
  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int DIR_ROWS = 22;

  logic clk = 1'b0;
  logic rst_n;

  logic                           cfg_wr_en;
  logic [nfas_pkg::REG_IDX_W-1:0] cfg_addr;
  logic [nfas_pkg::REG_W-1:0]     cfg_wdata;

  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // src_state[3:0], symbol[11:4], dst_state[15:12]
  logic [1:0]  in_tuser;   // action[1:0]

  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // active_set[15:0]
  logic [2:0]  out_tuser;  // accepted[0], dead[1], table_full[2]

  nfa_active_set_simulator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // The run is cut off well beyond the slowest correct run: every request a
  // full 64-entry scan, long sender gaps and receiver stalls, and the long hold.
  initial begin : watchdog
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Our own copy of the automaton: configuration, active set and the table.
  logic [3:0]          nfa_start;
  logic [15:0]         nfa_final;
  logic [15:0]         nfa_active;
  nfas_pkg::tt_entry_t nfa_table [nfas_pkg::MAX_TRANS_DEF];
  int                  nfa_count;

  // Results still owed by the block, oldest first.
  nfas_pkg::result_t awaited_results [$];
  int                mismatch_count = 0;

  // Idling knobs, changed only between phases; hold_start asks the receiver
  // for one long stretch of back-pressure.
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_start = 1'b0;

  // Applies one request to the automaton copy and returns the status the
  // block must report afterwards.
  function automatic nfas_pkg::result_t nfa_advance(input nfas_pkg::item_t req);
    nfas_pkg::result_t res;
    logic [15:0]       nxt;
    logic              dropped;
    int                i;
    dropped = 1'b0;
    case (req.action)
      nfas_pkg::ACT_CLEAR: begin
        // Only the count goes; the active set survives a clear.
        nfa_count = 0;
      end
      nfas_pkg::ACT_APPEND: begin
        if (nfa_count >= nfas_pkg::MAX_TRANS_DEF) begin
          dropped = 1'b1;
        end else begin
          nfa_table[nfa_count] = '{req.src_state, req.symbol, req.dst_state};
          nfa_count++;
        end
      end
      nfas_pkg::ACT_BEGIN: begin
        nfa_active = 16'd1 << nfa_start;
      end
      default: begin
        // A fed symbol: union of destinations of matching live transitions.
        nxt = '0;
        for (i = 0; i < nfa_count; i++) begin
          if (nfa_table[i].symbol == req.symbol &&
              nfa_active[nfa_table[i].src_state]) begin
            nxt[nfa_table[i].dst_state] = 1'b1;
          end
        end
        nfa_active = nxt;
      end
    endcase
    res.accepted   = |(nfa_active & nfa_final);
    res.dead       = (nfa_active == '0);
    res.active_set = nfa_active;
    res.table_full = dropped;
    return res;
  endfunction

  // Offers one request, possibly after a random gap, and records what it must
  // produce once the block takes it. A typed-in status replaces the predicted
  // one where the directed table gives it.
  task automatic send_req(input nfas_pkg::item_t req, input bit known,
                          input nfas_pkg::result_t known_res);
    nfas_pkg::result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {req.dst_state, req.symbol, req.src_state};
    in_tuser  <= req.action;
    do @(posedge clk); while (!in_tready);
    res = nfa_advance(req);
    awaited_results.insert(awaited_results.size(), known ? known_res : res);
  endtask

  task automatic offer(input nfas_pkg::action_t act, input logic [3:0] src,
                       input logic [7:0] sym, input logic [3:0] dst);
    nfas_pkg::item_t req;
    req = '{act, src, sym, dst};
    send_req(req, 1'b0, '0);
  endtask

  // Lets every owed result come back, then lets the bench settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the start state, then the final mask; only legal when idle.
  task automatic set_config(input logic [3:0] st, input logic [15:0] fm);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= nfas_pkg::REG_START_STATE;
    cfg_wdata <= {12'd0, st};
    @(posedge clk);
    nfa_start = st;
    cfg_addr  <= nfas_pkg::REG_FINAL_MASK;
    cfg_wdata <= fm;
    @(posedge clk);
    nfa_final = fm;
    cfg_wr_en <= 1'b0;
  endtask

  // Random traffic. Most of it is whole sessions: maybe a clear, a burst of
  // appends over a small pool of states and letters, a begin, then a run of
  // fed symbols mostly from that alphabet so the active set stays alive. Now
  // and then a burst is long enough to overflow the table. The rest is noise.
  task automatic random_items(input int n_items);
    logic [3:0] pool [4];
    logic [7:0] alpha [4];
    int         left;
    int         k;
    int         j;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(99) < 85) begin
        pool[0] = nfa_start;
        for (j = 1; j < 4; j++) pool[j] = 4'($urandom_range(15));
        for (j = 0; j < 4; j++) alpha[j] = 8'($urandom_range(255));
        if ($urandom_range(3) != 0) begin
          offer(nfas_pkg::ACT_CLEAR, 4'($urandom), 8'($urandom), 4'($urandom));
          left--;
        end
        k = ($urandom_range(24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        for (j = 0; j < k; j++) begin
          offer(nfas_pkg::ACT_APPEND, pool[$urandom_range(3)], alpha[$urandom_range(3)],
                pool[$urandom_range(3)]);
        end
        left -= k;
        offer(nfas_pkg::ACT_BEGIN, 4'($urandom), 8'($urandom), 4'($urandom));
        k = $urandom_range(1, 10);
        for (j = 0; j < k; j++) begin
          offer(nfas_pkg::ACT_FEED, 4'($urandom),
                ($urandom_range(9) != 0) ? alpha[$urandom_range(3)] : 8'($urandom),
                4'($urandom));
        end
        left -= k + 1;
      end else begin
        offer(nfas_pkg::action_t'($urandom_range(3)), 4'($urandom), 8'($urandom),
              4'($urandom));
        left--;
      end
    end
  endtask

  task automatic run_phase(input logic [3:0] st, input logic [15:0] fm, input int s_pct,
                           input int r_pct, input bit hold, input int n_items);
    wait_drained();
    set_config(st, fm);
    send_idle_pct = s_pct;
    stall_pct = r_pct;
    if (hold) begin
      hold_start = 1'b1;
    end
    random_items(n_items);
  endtask

  // Receiver: takes a result at every edge where valid and ready are both high,
  // compares it with the oldest owed status, and picks ready for the next cycle.
  initial begin : receiver
    nfas_pkg::result_t want;
    int                hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing owed: active_set %h", out_tdata);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser[0] !== want.accepted) begin
            $error("accepted: expected %b, got %b", want.accepted, out_tuser[0]);
            mismatch_count++;
          end
          if (out_tuser[1] !== want.dead) begin
            $error("dead: expected %b, got %b", want.dead, out_tuser[1]);
            mismatch_count++;
          end
          if (out_tuser[2] !== want.table_full) begin
            $error("table_full: expected %b, got %b", want.table_full, out_tuser[2]);
            mismatch_count++;
          end
          if (out_tdata !== want.active_set) begin
            $error("active_set: expected %h, got %h", want.active_set, out_tdata);
            mismatch_count++;
          end
        end
      end
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // Long back-pressure: the block fills up and must stall its input.
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Directed requests. A row repeats its request reps times. Where known is
  // set, the status after the request is typed in; otherwise it is predicted.
  typedef struct {
    nfas_pkg::action_t act;
    logic [3:0]        src;
    logic [7:0]        sym;
    logic [3:0]        dst;
    int                reps;
    bit                known;
    bit                acc;
    bit                dead;
    logic [15:0]       act_set;
    bit                full;
  } step_row_t;

  // Reset configuration applies: start state 0, no accepting states.
  step_row_t dir_rows [DIR_ROWS] = '{
    // Right after reset the set is empty, and the table too.
    '{nfas_pkg::ACT_FEED,   4'h0, 8'h00, 4'h0,  1, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0},
    // Begin ignores the other fields.
    '{nfas_pkg::ACT_BEGIN,  4'hf, 8'hff, 4'hf,  1, 1'b1, 1'b0, 1'b0, 16'h0001, 1'b0},
    // Feeding with an empty table kills the set.
    '{nfas_pkg::ACT_FEED,   4'h0, 8'h55, 4'h0,  1, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_APPEND, 4'h0, 8'h00, 4'hf,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_APPEND, 4'hf, 8'hff, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_APPEND, 4'h0, 8'h00, 4'h1,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_APPEND, 4'h1, 8'h00, 4'h1,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_BEGIN,  4'h0, 8'h00, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_FEED,   4'h0, 8'h00, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_FEED,   4'h0, 8'hff, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_FEED,   4'h0, 8'h12, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // A dead set stays dead.
    '{nfas_pkg::ACT_FEED,   4'h0, 8'h00, 4'h0,  1, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0},
    // Clear keeps the (empty) active set.
    '{nfas_pkg::ACT_CLEAR,  4'hf, 8'hff, 4'hf,  1, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_BEGIN,  4'h0, 8'h00, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_CLEAR,  4'h0, 8'h00, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_FEED,   4'h0, 8'h00, 4'h0,  1, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0},
    // Fill the whole table, then scan all of it.
    '{nfas_pkg::ACT_APPEND, 4'h0, 8'ha5, 4'h0, 64, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_BEGIN,  4'h0, 8'h00, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_FEED,   4'h0, 8'ha5, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // Append to a full table is dropped and flagged.
    '{nfas_pkg::ACT_APPEND, 4'h3, 8'h3c, 4'hc,  1, 1'b1, 1'b0, 1'b0, 16'h0001, 1'b1},
    '{nfas_pkg::ACT_FEED,   4'h0, 8'ha5, 4'h0,  1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{nfas_pkg::ACT_CLEAR,  4'h0, 8'h00, 4'h0,  1, 1'b1, 1'b0, 1'b0, 16'h0001, 1'b0}
  };

  initial begin : stimulus
    step_row_t         row;
    nfas_pkg::item_t   req;
    nfas_pkg::result_t fixed_res;
    int                r;
    int                n;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= nfas_pkg::REG_START_STATE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= nfas_pkg::ACT_CLEAR;
    nfa_start = '0;
    nfa_final = '0;
    nfa_active = '0;
    nfa_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling.
    for (r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      req = '{row.act, row.src, row.sym, row.dst};
      fixed_res.accepted   = row.acc;
      fixed_res.dead       = row.dead;
      fixed_res.active_set = row.act_set;
      fixed_res.table_full = row.full;
      for (n = 0; n < row.reps; n++) begin
        send_req(req, row.known, fixed_res);
      end
    end

    // Random phases over several configurations, the extremes among them,
    // and each idling mode; one phase holds the receiver off for a long time.
    run_phase(4'hf, 16'hffff, 0, 0, 1'b0, 60);
    run_phase(4'h0, 16'h0001, 69, 0, 1'b0, 55);
    run_phase(4'($urandom_range(15)), 16'($urandom), 0, 69, 1'b0, 55);
    run_phase(4'($urandom_range(15)), 16'h8000, 30, 30, 1'b0, 55);
    run_phase(4'($urandom_range(15)), 16'($urandom), 0, 0, 1'b1, 55);
    run_phase(4'h0, 16'h0000, 0, 0, 1'b0, 55);
    wait_drained();

    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/nfas_pkg.sv
hdl/nfas_engine.sv
hdl/nfa_active_set_simulator.sv
test/testbench.sv
